// ----- sv/oys_pkg.sv -----
// Shared types and constants for the oldest-yield thread scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package oys_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int STAMP_W = 64;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 16;

    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    typedef enum logic [2:0] {
        MODE_CREATE  = 3'd0,
        MODE_SWITCH  = 3'd1,
        MODE_YIELD   = 3'd2,
        MODE_EXIT    = 3'd3,
        MODE_COYIELD = 3'd4,
        MODE_KILL    = 3'd5,
        MODE_COLLECT = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DISABLED = 2'd1,
        STATUS_BAD_SLOT = 2'd2,
        STATUS_NO_RUN   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_UNSTARTED    = 3'd0,
        ST_RUNNING      = 3'd1,
        ST_SUSPENDED    = 3'd2,
        ST_JOIN_WAIT    = 3'd3,
        ST_COYIELD_WAIT = 3'd4,
        ST_KILLED       = 3'd5
    } slot_state_t;

    typedef enum logic [2:0] {
        CTRL_IDLE,
        CTRL_EXEC,
        CTRL_SCAN,
        CTRL_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic scan_step;
        logic scan_end;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic running_used;
    } dp_stat_t;

endpackage

// ----- sv/oys_ctrl.sv -----
// Sequencing controller for the oldest-yield thread scheduler.
// Depends on oys_pkg; drives the datapath commands and both handshakes.
module oys_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  oys_pkg::dp_stat_t stat,
    output oys_pkg::dp_cmd_t  cmd
);
    import oys_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CTRL_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = CTRL_EXEC;
                end
            end
            CTRL_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = CTRL_SCAN;
            end
            CTRL_SCAN:
            begin
                if (!stat.need_scan)
                begin
                    state_next = CTRL_FINISH;
                end
                else if (stat.scan_done)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = CTRL_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            CTRL_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- sv/oys_datapath.sv -----
// Datapath of the oldest-yield thread scheduler: slot table, stamp memory,
// oldest-stamp scan and result register. Depends on oys_pkg.
module oys_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  oys_pkg::dp_cmd_t           cmd,
    output oys_pkg::dp_stat_t          stat,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic [oys_pkg::IN_W-1:0]   in_data,
    output logic [oys_pkg::OUT_W-1:0]  out_data
);
    import oys_pkg::*;

    mode_t       mode_reg;
    mode_t       mode_next;
    slot_idx_t   tgt_reg;
    slot_idx_t   tgt_next;
    logic        run_now_reg;
    logic        run_now_next;
    stamp_t      now_reg;
    stamp_t      now_next;

    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] used_next;
    slot_state_t      state_reg [SLOTS];
    slot_state_t      state_next [SLOTS];
    logic [SLOTS-1:0] stamp_ok_reg;
    logic [SLOTS-1:0] stamp_ok_next;
    slot_idx_t        running_reg;
    slot_idx_t        running_next;
    logic             en_reg;
    logic             en_next;

    status_t     status_reg;
    status_t     status_next;
    slot_idx_t   new_slot_reg;
    slot_idx_t   new_slot_next;
    slot_idx_t   rep_reg;
    slot_idx_t   rep_next;
    logic        rep_ok_reg;
    logic        rep_ok_next;
    slot_idx_t   prev_reg;
    slot_idx_t   prev_next;
    logic        need_scan_reg;
    logic        need_scan_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pend_reg;
    logic             pend_next;
    logic             found_reg;
    logic             found_next;
    slot_idx_t        best_reg;
    slot_idx_t        best_next;
    stamp_t           best_ts_reg;
    stamp_t           best_ts_next;

    stamp_t      stamp_mem [SLOTS];
    stamp_t      rd_data_reg;
    logic        rd_ok_reg;
    slot_idx_t   rd_idx_reg;
    slot_idx_t   rd_addr;
    logic        stamp_we;

    logic [OUT_W-1:0] out_reg;
    logic [OUT_W-1:0] out_next;

    logic        tgt_ok;
    logic        free_found;
    slot_idx_t   free_slot;
    logic        go_en;
    slot_idx_t   go_slot;
    stamp_t      rd_ts;
    logic        rd_runnable;
    logic [2:0]  rep_state;

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    assign tgt_ok      = used_reg[tgt_reg];
    assign rd_addr     = cnt_reg[SLOT_W-1:0];
    assign rd_ts       = rd_ok_reg ? rd_data_reg : '0;
    assign rd_runnable = used_reg[rd_idx_reg] &&
                         (state_reg[rd_idx_reg] == ST_UNSTARTED ||
                          state_reg[rd_idx_reg] == ST_SUSPENDED);

    always_comb
    begin
        mode_next      = mode_reg;
        tgt_next       = tgt_reg;
        run_now_next   = run_now_reg;
        now_next       = now_reg;
        used_next      = used_reg;
        state_next     = state_reg;
        stamp_ok_next  = stamp_ok_reg;
        running_next   = running_reg;
        en_next        = en_reg;
        status_next    = status_reg;
        new_slot_next  = new_slot_reg;
        rep_next       = rep_reg;
        rep_ok_next    = rep_ok_reg;
        prev_next      = prev_reg;
        need_scan_next = need_scan_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_ts_next   = best_ts_reg;
        stamp_we       = 1'b0;
        go_en          = 1'b0;
        go_slot        = tgt_reg;

        if (cfg_we)
        begin
            en_next = cfg_wdata;
        end

        if (cmd.load_item)
        begin
            mode_next      = mode_t'(in_data[2:0]);
            tgt_next       = in_data[6:3];
            run_now_next   = in_data[7];
            now_next       = in_data[71:8];
            prev_next      = running_reg;
            status_next    = STATUS_OK;
            new_slot_next  = '0;
            rep_next       = running_reg;
            rep_ok_next    = 1'b1;
            need_scan_next = 1'b0;
        end

        if (cmd.exec)
        begin
            cnt_next   = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
            case (mode_reg)
                MODE_CREATE:
                begin
                    status_next = STATUS_BAD_SLOT;
                    if (free_found)
                    begin
                        used_next[free_slot]     = 1'b1;
                        state_next[free_slot]    = ST_UNSTARTED;
                        stamp_ok_next[free_slot] = 1'b0;
                        new_slot_next            = free_slot;
                        rep_next                 = free_slot;
                        status_next              = STATUS_OK;
                        if (run_now_reg)
                        begin
                            if (!en_reg)
                            begin
                                status_next = STATUS_DISABLED;
                            end
                            else
                            begin
                                go_en   = 1'b1;
                                go_slot = free_slot;
                            end
                        end
                    end
                end
                MODE_SWITCH:
                begin
                    rep_next = tgt_reg;
                    if (!tgt_ok)
                    begin
                        status_next = STATUS_BAD_SLOT;
                        rep_ok_next = 1'b0;
                    end
                    else if (!en_reg)
                    begin
                        status_next = STATUS_DISABLED;
                    end
                    else
                    begin
                        go_en = 1'b1;
                    end
                end
                MODE_YIELD, MODE_EXIT, MODE_COYIELD:
                begin
                    if (mode_reg == MODE_EXIT)
                    begin
                        state_next[running_reg] = ST_JOIN_WAIT;
                    end
                    else if (mode_reg == MODE_COYIELD)
                    begin
                        state_next[running_reg] = ST_COYIELD_WAIT;
                    end
                    if (!en_reg)
                    begin
                        status_next = STATUS_DISABLED;
                    end
                    else
                    begin
                        stamp_we                   = 1'b1;
                        stamp_ok_next[running_reg] = 1'b1;
                        need_scan_next             = 1'b1;
                    end
                end
                MODE_KILL:
                begin
                    rep_next = tgt_reg;
                    if (!tgt_ok || tgt_reg == running_reg)
                    begin
                        status_next = STATUS_BAD_SLOT;
                        rep_ok_next = tgt_ok;
                    end
                    else
                    begin
                        used_next[tgt_reg]  = 1'b0;
                        state_next[tgt_reg] = ST_KILLED;
                    end
                end
                MODE_COLLECT:
                begin
                    rep_next = tgt_reg;
                    if (!tgt_ok)
                    begin
                        status_next = STATUS_BAD_SLOT;
                        rep_ok_next = 1'b0;
                    end
                    else if (state_reg[tgt_reg] == ST_COYIELD_WAIT)
                    begin
                        state_next[tgt_reg] = ST_SUSPENDED;
                    end
                    else if (state_reg[tgt_reg] == ST_JOIN_WAIT)
                    begin
                        status_next = STATUS_OK;
                    end
                    else if (!en_reg)
                    begin
                        status_next = STATUS_DISABLED;
                    end
                    else
                    begin
                        go_en = 1'b1;
                    end
                end
                default:
                begin
                    status_next = STATUS_BAD_SLOT;
                end
            endcase
        end

        if (cmd.scan_step)
        begin
            if (cnt_reg < CNT_W'(SLOTS))
            begin
                pend_next = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
            if (pend_reg && rd_runnable && (!found_reg || rd_ts < best_ts_reg))
            begin
                found_next   = 1'b1;
                best_next    = rd_idx_reg;
                best_ts_next = rd_ts;
            end
        end

        if (cmd.scan_end)
        begin
            if (!found_reg)
            begin
                status_next = STATUS_NO_RUN;
            end
            else
            begin
                go_en   = 1'b1;
                go_slot = best_reg;
            end
        end

        if (go_en)
        begin
            if (state_next[running_reg] == ST_RUNNING)
            begin
                state_next[running_reg] = ST_SUSPENDED;
            end
            running_next        = go_slot;
            state_next[go_slot] = ST_RUNNING;
        end
    end

    assign rep_state = rep_ok_reg ? 3'(state_reg[rep_reg]) : 3'd0;

    always_comb
    begin
        out_next = out_reg;
        if (cmd.load_out)
        begin
            out_next = {2'b00, (running_reg != prev_reg), rep_state, new_slot_reg,
                        running_reg, 2'(status_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= SLOTS'(1);
            for (int i = 0; i < SLOTS; i++)
            begin
                state_reg[i] <= (i == 0) ? ST_RUNNING : ST_UNSTARTED;
            end
            stamp_ok_reg  <= '0;
            running_reg   <= '0;
            en_reg        <= 1'b0;
            need_scan_reg <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            state_reg     <= state_next;
            stamp_ok_reg  <= stamp_ok_next;
            running_reg   <= running_next;
            en_reg        <= en_next;
            need_scan_reg <= need_scan_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        tgt_reg      <= tgt_next;
        run_now_reg  <= run_now_next;
        now_reg      <= now_next;
        status_reg   <= status_next;
        new_slot_reg <= new_slot_next;
        rep_reg      <= rep_next;
        rep_ok_reg   <= rep_ok_next;
        prev_reg     <= prev_next;
        best_reg     <= best_next;
        best_ts_reg  <= best_ts_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[running_reg] <= now_reg;
        end
        rd_data_reg <= stamp_mem[rd_addr];
        rd_ok_reg   <= stamp_ok_reg[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    assign stat.need_scan    = need_scan_reg;
    assign stat.scan_done    = !pend_reg && (cnt_reg == CNT_W'(SLOTS));
    assign stat.running_used = used_reg[running_reg];
    assign out_data          = out_reg;

endmodule

// ----- sv/oldest_yield_thread_scheduler_core.sv -----
// Top level of the oldest-yield thread scheduler.
// Depends on oys_pkg, oys_ctrl and oys_datapath.
//
// Each accepted event is handled alone and yields one result transaction.
// Create, switch, kill, collect and refused events skip the scan; a yield,
// exit or co-yield with switching enabled runs the scan, which reads one
// slot stamp per cycle from the 16-entry stamp memory. A new event is
// taken as soon as the previous one has been placed in the output
// register, even while that result still waits for the downstream side.
module oldest_yield_thread_scheduler_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0: mode[2:0], target[6:3], run_now[7], now[71:8].
    input  logic [oys_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // Fields from bit 0: status[1:0], active[5:2], new_slot[9:6],
    // target_state[12:10], switched[13], zero[15:14].
    output logic [oys_pkg::OUT_W-1:0] m_tdata
);
    import oys_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    oys_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    oys_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    a_running_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
        stat.running_used)
        else $error("running slot is not marked used");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.exec, cmd.scan_step, cmd.scan_end, cmd.load_out}))
        else $error("more than one datapath command in a cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new event accepted while one is in progress");
`endif

endmodule

// ----- tb/sv/tb_oldest_yield_thread_scheduler_core.sv -----
// Self-checking testbench for oldest_yield_thread_scheduler_core.
// Depends on oys_pkg and the scheduler RTL; a scripted part is followed by
// random event streams, each result checked against a scheduler model or a fixed value.
module tb_oldest_yield_thread_scheduler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import oys_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int SCRIPT_LEN = 25;
    localparam int PHASE_ITEMS = 105;
    localparam int DRAIN_CYCLES = 25;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [2:0] mode;
        slot_idx_t  tgt;
        logic       run_now;
        stamp_t     now;
    } stim_t;

    typedef struct packed {
        logic [1:0] status;
        slot_idx_t  active;
        slot_idx_t  new_slot;
        logic [2:0] tstate;
        logic       switched;
    } sched_result_t;

    typedef struct {
        logic          en;
        stim_t         ev;
        int            reps;
        logic          fixed;
        sched_result_t res;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;

    logic                 fixed_flag;
    sched_result_t        fixed_res;
    bit                   hold_req;
    logic                 cur_en;
    int                   err_count;

    logic                 thr_used [SLOTS];
    slot_state_t          thr_state [SLOTS];
    stamp_t               thr_stamp [SLOTS];
    slot_idx_t            cur_slot;
    logic                 model_sw_en;

    sched_result_t        expected_results [$];

    script_row_t script [SCRIPT_LEN] = '{
        '{1'b0, '{MODE_YIELD,   4'd0,  1'b0, 64'd0}, 1, 1'b1,
          '{STATUS_DISABLED, 4'd0, 4'd0, ST_RUNNING, 1'b0}},
        '{1'b0, '{MODE_SWITCH,  4'd0,  1'b0, 64'd0}, 1, 1'b1,
          '{STATUS_DISABLED, 4'd0, 4'd0, ST_RUNNING, 1'b0}},
        '{1'b0, '{MODE_SWITCH,  4'd15, 1'b0, 64'd0}, 1, 1'b1,
          '{STATUS_BAD_SLOT, 4'd0, 4'd0, 3'd0, 1'b0}},
        '{1'b0, '{MODE_KILL,    4'd0,  1'b0, 64'd0}, 1, 1'b1,
          '{STATUS_BAD_SLOT, 4'd0, 4'd0, ST_RUNNING, 1'b0}},
        '{1'b0, '{MODE_UNUSED,  4'd9,  1'b1, 64'd0}, 1, 1'b1,
          '{STATUS_BAD_SLOT, 4'd0, 4'd0, ST_RUNNING, 1'b0}},
        '{1'b1, '{MODE_YIELD,   4'd0,  1'b0, 64'd7}, 1, 1'b1,
          '{STATUS_NO_RUN, 4'd0, 4'd0, ST_RUNNING, 1'b0}},
        '{1'b0, '{MODE_CREATE,  4'd0,  1'b1, 64'd0}, 1, 1'b1,
          '{STATUS_DISABLED, 4'd0, 4'd1, ST_UNSTARTED, 1'b0}},
        '{1'b0, '{MODE_EXIT,    4'd0,  1'b0, 64'd3}, 1, 1'b1,
          '{STATUS_DISABLED, 4'd0, 4'd0, ST_JOIN_WAIT, 1'b0}},
        '{1'b0, '{MODE_COLLECT, 4'd0,  1'b0, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_CREATE,  4'd0,  1'b0, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_YIELD,   4'd0,  1'b0, '1},    1, 1'b0, '0},
        '{1'b1, '{MODE_COYIELD, 4'd0,  1'b0, 64'd5}, 1, 1'b0, '0},
        '{1'b1, '{MODE_COLLECT, 4'd1,  1'b0, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_YIELD,   4'd0,  1'b0, '1},    1, 1'b0, '0},
        '{1'b1, '{MODE_YIELD,   4'd0,  1'b0, '1},    1, 1'b0, '0},
        '{1'b1, '{MODE_KILL,    4'd2,  1'b0, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_COLLECT, 4'd3,  1'b0, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_SWITCH,  4'd0,  1'b0, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_CREATE,  4'd0,  1'b1, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_CREATE,  4'd0,  1'b0, 64'd0}, 13, 1'b0, '0},
        '{1'b1, '{MODE_CREATE,  4'd0,  1'b1, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_KILL,    4'd15, 1'b0, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_COLLECT, 4'd15, 1'b0, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_EXIT,    4'd0,  1'b0, 64'd0}, 1, 1'b0, '0},
        '{1'b1, '{MODE_COLLECT, 4'd5,  1'b0, 64'd0}, 1, 1'b0, '0}
    };

    oldest_yield_thread_scheduler_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void enter_slot(slot_idx_t s);
        if (thr_state[cur_slot] == ST_RUNNING)
            thr_state[cur_slot] = ST_SUSPENDED;
        cur_slot = s;
        thr_state[s] = ST_RUNNING;
    endfunction

    function automatic logic [1:0] switch_to(slot_idx_t s);
        if (!model_sw_en)
            return STATUS_DISABLED;
        enter_slot(s);
        return STATUS_OK;
    endfunction

    function automatic logic [1:0] yield_and_pick(stamp_t now);
        slot_idx_t best;
        bit        found;
        stamp_t    best_ts;
        best = '0;
        found = 1'b0;
        best_ts = '0;
        if (!model_sw_en)
            return STATUS_DISABLED;
        thr_stamp[cur_slot] = now;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (thr_used[i] && (thr_state[i] == ST_UNSTARTED || thr_state[i] == ST_SUSPENDED)
                && (!found || thr_stamp[i] < best_ts))
            begin
                found = 1'b1;
                best = slot_idx_t'(i);
                best_ts = thr_stamp[i];
            end
        end
        if (!found)
            return STATUS_NO_RUN;
        enter_slot(best);
        return STATUS_OK;
    endfunction

    function automatic sched_result_t schedule_event(stim_t ev);
        sched_result_t r;
        slot_idx_t     prev;
        slot_idx_t     rep;
        logic [1:0]    st;
        logic          tok;
        logic          rep_ok;
        prev = cur_slot;
        rep = prev;
        st = STATUS_OK;
        r = '0;
        tok = thr_used[ev.tgt];
        rep_ok = 1'b1;
        case (ev.mode)
            MODE_CREATE:
            begin
                st = STATUS_BAD_SLOT;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!thr_used[i])
                    begin
                        thr_used[i] = 1'b1;
                        thr_state[i] = ST_UNSTARTED;
                        thr_stamp[i] = '0;
                        r.new_slot = slot_idx_t'(i);
                        rep = slot_idx_t'(i);
                        st = ev.run_now ? switch_to(slot_idx_t'(i)) : STATUS_OK;
                        break;
                    end
                end
            end
            MODE_SWITCH:
            begin
                rep = ev.tgt;
                if (!tok)
                begin
                    st = STATUS_BAD_SLOT;
                    rep_ok = 1'b0;
                end
                else
                    st = switch_to(ev.tgt);
            end
            MODE_YIELD:
                st = yield_and_pick(ev.now);
            MODE_EXIT:
            begin
                thr_state[cur_slot] = ST_JOIN_WAIT;
                st = yield_and_pick(ev.now);
            end
            MODE_COYIELD:
            begin
                thr_state[cur_slot] = ST_COYIELD_WAIT;
                st = yield_and_pick(ev.now);
            end
            MODE_KILL:
            begin
                rep = ev.tgt;
                if (!tok || ev.tgt == cur_slot)
                begin
                    st = STATUS_BAD_SLOT;
                    rep_ok = tok;
                end
                else
                begin
                    thr_used[ev.tgt] = 1'b0;
                    thr_state[ev.tgt] = ST_KILLED;
                end
            end
            MODE_COLLECT:
            begin
                rep = ev.tgt;
                if (!tok)
                begin
                    st = STATUS_BAD_SLOT;
                    rep_ok = 1'b0;
                end
                else if (thr_state[ev.tgt] == ST_COYIELD_WAIT)
                    thr_state[ev.tgt] = ST_SUSPENDED;
                else if (thr_state[ev.tgt] != ST_JOIN_WAIT)
                    st = switch_to(ev.tgt);
            end
            default:
                st = STATUS_BAD_SLOT;
        endcase
        r.status = st;
        r.active = cur_slot;
        r.tstate = rep_ok ? thr_state[rep] : 3'd0;
        r.switched = (cur_slot != prev);
        return r;
    endfunction

    // The model follows the block at each accepted transaction and each register write.
    always @(posedge clk)
    begin : accept_mon
        sched_result_t pred;
        if (rst_n)
        begin
            if (cfg_we)
                model_sw_en = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                pred = schedule_event(stim_t'{s_tdata[2:0], s_tdata[6:3], s_tdata[7],
                                              s_tdata[71:8]});
                if (fixed_flag)
                    pred = fixed_res;
                expected_results.push_back(pred);
            end
        end
    end

    always @(posedge clk)
    begin : result_chk
        sched_result_t exp_r;
        sched_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[1:0];
            got.active = m_tdata[5:2];
            got.new_slot = m_tdata[9:6];
            got.tstate = m_tdata[12:10];
            got.switched = m_tdata[13];
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no expected result: %h", m_tdata);
                err_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                    err_count++;
                end
                if (got.active !== exp_r.active)
                begin
                    $error("active: expected %0d, actual %0d", exp_r.active, got.active);
                    err_count++;
                end
                if (got.new_slot !== exp_r.new_slot)
                begin
                    $error("new_slot: expected %0d, actual %0d", exp_r.new_slot, got.new_slot);
                    err_count++;
                end
                if (got.tstate !== exp_r.tstate)
                begin
                    $error("target_state: expected %0d, actual %0d", exp_r.tstate, got.tstate);
                    err_count++;
                end
                if (got.switched !== exp_r.switched)
                begin
                    $error("switched: expected %0d, actual %0d", exp_r.switched, got.switched);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : result_sink
        int n;
        int k;
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
                m_tready <= 1'b1;
                repeat (n) @(posedge clk);
                k = pick_gap();
                if (k > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (k) @(posedge clk);
                end
            end
        end
    end

    task automatic send_event(stim_t ev, logic fixed, sched_result_t res, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ev.now, ev.run_now, ev.tgt, ev.mode};
        fixed_flag <= fixed;
        fixed_res <= res;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_switching(logic v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_en = v;
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        fixed_flag = 1'b0;
        fixed_res = '0;
        hold_req = 1'b0;
        err_count = 0;
        cur_en = 1'b0;
        model_sw_en = 1'b0;
        cur_slot = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            thr_used[i] = (i == 0);
            thr_state[i] = (i == 0) ? ST_RUNNING : ST_UNSTARTED;
            thr_stamp[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (script[r])
        begin
            if (script[r].en != cur_en)
            begin
                wait_idle();
                set_switching(script[r].en);
            end
            repeat (script[r].reps)
                send_event(script[r].ev, script[r].fixed, script[r].res, pick_gap());
        end

        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            set_switching((p == 1 || p == 4) ? 1'b0 : 1'b1);
            if (p == 0)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin : gen
                stim_t     ev;
                int        pick;
                int        nused;
                int        k;
                slot_idx_t chosen;
                nused = 0;
                chosen = cur_slot;
                foreach (thr_used[i])
                    if (thr_used[i])
                        nused++;
                k = $urandom_range(0, (nused > 0) ? nused - 1 : 0);
                foreach (thr_used[i])
                begin
                    if (thr_used[i])
                    begin
                        if (k == 0)
                            chosen = slot_idx_t'(i);
                        k--;
                    end
                end
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    ev.mode = MODE_CREATE;
                else if (pick < 34)
                    ev.mode = MODE_SWITCH;
                else if (pick < 52)
                    ev.mode = MODE_YIELD;
                else if (pick < 60)
                    ev.mode = MODE_EXIT;
                else if (pick < 70)
                    ev.mode = MODE_COYIELD;
                else if (pick < 82)
                    ev.mode = MODE_KILL;
                else if (pick < 97)
                    ev.mode = MODE_COLLECT;
                else
                    ev.mode = MODE_UNUSED;
                ev.tgt = ($urandom_range(0, 3) == 0) ? slot_idx_t'($urandom_range(0, 15)) : chosen;
                ev.run_now = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0: ev.now = '0;
                    1: ev.now = '1;
                    2, 3, 4: ev.now = stamp_t'($urandom_range(0, 15));
                    default: ev.now = {$urandom, $urandom};
                endcase
                send_event(ev, 1'b0, '0, pick_gap());
            end
        end

        wait_idle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
